// ===== hw/rtl/mbps_pkg.sv =====
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int MAX_PATTERN_BYTES_DEF = 32;
  localparam int OFFSET_BITS_DEF       = 32;

  // Pattern storage that the register map provides.
  localparam int REG_PATTERN_BYTES = 32;

  localparam int DATA_W   = 8;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int MASK_W   = 32;
  localparam int LEN_W    = 6;
  localparam int ADDR_W   = 64;
  localparam int SEEN_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_0_7   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_8_15  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_16_23 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_24_31 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BASE      = 3'd6;

  // Control that the top level hands to every cell of the chain.
  typedef struct packed {
    logic shift;
    logic clear;
  } chain_ctrl_t;

endpackage

// ===== hw/rtl/masked_byte_pattern_scan_core.sv =====
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_core
// Wildcard byte pattern search over a streamed memory image.
// ----------------------------------------------------------------------------
// The block takes one image byte per clock cycle, back to back, unless the
// output stalls, and gives its result in the cycle after the byte that causes
// it, from an output register that drains in the same cycle in which a new
// item is taken. The match chain has one cell per pattern byte, each updating
// once per byte: cell k records whether the newest bytes equal pattern bytes
// 0 to k under the compare mask, and a match is read at the cell that the
// pattern length selects. The found address is base address plus the match
// offset, formed in the cycle that accepts the matching byte.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan_core
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
  parameter int OFFSET_BITS       = OFFSET_BITS_DEF
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DATA_W-1:0]    in_data_byte,
  input  logic                 in_last_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_found,
  output logic [ADDR_W-1:0]    out_match_address
);

  localparam logic [ADDR_W-1:0] OFF_MASK =
    (OFFSET_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
                            : ((ADDR_W'(1) << OFFSET_BITS) - ADDR_W'(1));

  logic [REG_PATTERN_BYTES*DATA_W-1:0] pattern_r;
  logic [MASK_W-1:0]                   mask_r;
  logic [LEN_W-1:0]                    len_r;
  logic [ADDR_W-1:0]                   base_r;

  logic [SEEN_W-1:0] seen_r;
  logic [SEEN_W-1:0] seen_nxt;
  logic              reported_r;
  logic              reported_nxt;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_found_r;
  logic              out_found_nxt;
  logic [ADDR_W-1:0] out_addr_r;
  logic [ADDR_W-1:0] out_addr_nxt;

  logic                         in_acc;
  chain_ctrl_t                  ctrl;
  logic [MAX_PATTERN_BYTES-1:0] hit_nxt;
  logic                         hit;
  logic [SEEN_W-1:0]            off;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      mask_r    <= '0;
      len_r     <= '0;
      base_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAT_0_7:   pattern_r[0*CFG_W +: CFG_W] <= cfg_wdata;
        REG_PAT_8_15:  pattern_r[1*CFG_W +: CFG_W] <= cfg_wdata;
        REG_PAT_16_23: pattern_r[2*CFG_W +: CFG_W] <= cfg_wdata;
        REG_PAT_24_31: pattern_r[3*CFG_W +: CFG_W] <= cfg_wdata;
        REG_MASK:      mask_r <= cfg_wdata[MASK_W-1:0];
        REG_LENGTH:    len_r  <= cfg_wdata[LEN_W-1:0];
        REG_BASE:      base_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready = ~out_valid_r | out_ready;
  assign in_acc   = in_valid & in_ready;

  assign ctrl.shift = in_acc & ~reported_r;
  assign ctrl.clear = in_acc & in_last_byte;

  mbps_chain #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_chain (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .data_byte    (in_data_byte),
    .pattern      (pattern_r),
    .compare_mask (mask_r),
    .hit_nxt      (hit_nxt)
  );

  // Pick the cell that ends the configured pattern; lengths beyond the
  // register map or the chain never match, nor does zero.
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      if (i < REG_PATTERN_BYTES && int'(len_r) == i + 1) begin
        hit = hit_nxt[i];
      end
    end
  end

  always_comb begin
    seen_nxt      = (seen_r == {SEEN_W{1'b1}}) ? seen_r : seen_r + SEEN_W'(1);
    off           = seen_nxt - SEEN_W'(len_r);
    reported_nxt  = reported_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;
    if (ctrl.shift) begin
      if (hit) begin
        reported_nxt  = 1'b1;
        out_valid_nxt = 1'b1;
        out_found_nxt = 1'b1;
        out_addr_nxt  = base_r + (ADDR_W'(off) & OFF_MASK);
      end else if (in_last_byte) begin
        out_valid_nxt = 1'b1;
        out_found_nxt = 1'b0;
        out_addr_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      reported_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (ctrl.clear) begin
        seen_r     <= '0;
        reported_r <= 1'b0;
      end else begin
        if (ctrl.shift) begin
          seen_r <= seen_nxt;
        end
        reported_r <= reported_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_addr_r  <= out_addr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_address = out_addr_r;

  // A not-found result always carries a zero address.
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_found || out_match_address == '0))
    else $error("not-found result with nonzero address");

  // The last byte of an image leaves the image state clear.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_byte) |=> (!reported_r && seen_r == '0))
    else $error("image state not cleared after last byte");

  // Bytes after a match produce no result.
  a_quiet_after_match: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && reported_r) |=> !out_valid)
    else $error("result issued after a match was reported");

  // A zero-length pattern never reports a match.
  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.shift && len_r == '0) |=> !(out_valid && out_found))
    else $error("match reported for zero-length pattern");

endmodule

// ===== hw/rtl/mbps_cell.sv =====
// ----------------------------------------------------------------------------
// mbps_cell
// One cell of the match chain: holds whether the newest bytes match a
// prefix of the pattern that ends at this cell's pattern byte.
// ----------------------------------------------------------------------------
module mbps_cell
  import mbps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  chain_ctrl_t       ctrl,
  input  logic [DATA_W-1:0] data_byte,
  input  logic [DATA_W-1:0] pat_byte,
  input  logic              care,
  input  logic              prev_hit,
  output logic              hit_nxt,
  output logic              hit_r
);

  logic byte_ok;

  // A wildcard byte matches anything.
  assign byte_ok = ~care | (data_byte == pat_byte);
  assign hit_nxt = prev_hit & byte_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctrl.clear) begin
      hit_r <= 1'b0;
    end else if (ctrl.shift) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

// ===== hw/rtl/mbps_chain.sv =====
// ----------------------------------------------------------------------------
// mbps_chain
// Row of match cells. Cell k compares the incoming byte with pattern byte k
// and takes the prefix result of cell k-1 from the previous byte.
// ----------------------------------------------------------------------------
module mbps_chain
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
)
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  chain_ctrl_t                  ctrl,
  input  logic [DATA_W-1:0]            data_byte,
  input  logic [REG_PATTERN_BYTES*DATA_W-1:0] pattern,
  input  logic [MASK_W-1:0]            compare_mask,
  output logic [MAX_PATTERN_BYTES-1:0] hit_nxt
);

  logic [MAX_PATTERN_BYTES-1:0] hit_r;

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    logic [DATA_W-1:0] pat_byte;
    logic              care;
    logic              prev_hit;

    // Cells past the register map never decide a match.
    if (k < REG_PATTERN_BYTES) begin : g_pat
      assign pat_byte = pattern[k*DATA_W +: DATA_W];
      assign care     = compare_mask[k];
    end else begin : g_nopat
      assign pat_byte = '0;
      assign care     = 1'b0;
    end

    if (k == 0) begin : g_head
      assign prev_hit = 1'b1;
    end else begin : g_link
      assign prev_hit = hit_r[k-1];
    end

    mbps_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .data_byte (data_byte),
      .pat_byte  (pat_byte),
      .care      (care),
      .prev_hit  (prev_hit),
      .hit_nxt   (hit_nxt[k]),
      .hit_r     (hit_r[k])
    );
  end

endmodule

// ===== test/masked_byte_pattern_scan_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_core_test
// Streams byte images through the masked pattern scanner and checks each
// found / not-found result against a cycle-free model of the scan, kept in
// step with every accepted byte. Runs a few directed images, then random
// register settings with images that mostly carry the pattern, near misses
// and plain noise, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan_core_test;
  import mbps_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS      = 165;
  localparam int RANDOM_PHASES    = 12;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              last;
  } image_byte_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } scan_outcome_t;

  typedef logic [DATA_W-1:0] byte_list_t[$];

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [DATA_W-1:0]    in_data_byte = '0;
  logic                 in_last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_found;
  logic [ADDR_W-1:0]    out_match_address;

  masked_byte_pattern_scan_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_match_address (out_match_address)
  );

  // Scanner model: register copies and per-image state.
  logic [CFG_W-1:0]  pat_words [4] = '{default: '0};
  logic [MASK_W-1:0] cmp_mask = '0;
  logic [LEN_W-1:0]  pat_len = '0;
  logic [ADDR_W-1:0] base_addr = '0;
  logic [DATA_W-1:0] recent_bytes [REG_PATTERN_BYTES] = '{default: '0};
  logic [SEEN_W-1:0] image_count = '0;
  logic              image_done = 1'b0;

  image_byte_t   image_bytes_q[$];
  scan_outcome_t awaited_outcomes[$];
  image_byte_t   offered_byte;
  scan_outcome_t awaited;

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  gap_left = 0;
  int  hold_left = 0;
  logic gaps_on = 1'b1;
  logic stalls_on = 1'b1;
  logic hold_request = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [DATA_W-1:0] pattern_byte(int j);
    return pat_words[j / 8][(j % 8) * 8 +: 8];
  endfunction

  function automatic logic window_hit();
    int len;
    len = int'(pat_len);
    if (len == 0 || len > REG_PATTERN_BYTES) return 1'b0;
    if (image_count < SEEN_W'(len)) return 1'b0;
    for (int j = 0; j < len; j++) begin
      if (cmp_mask[j] && recent_bytes[len - 1 - j] != pattern_byte(j)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advances the model by one accepted byte and records any outcome it causes.
  function automatic void scan_byte(logic [DATA_W-1:0] data, logic last);
    scan_outcome_t res;
    logic [SEEN_W-1:0] offset;
    if (!image_done) begin
      for (int k = REG_PATTERN_BYTES - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k - 1];
      recent_bytes[0] = data;
      if (image_count != '1) image_count = image_count + 1'b1;
      if (window_hit()) begin
        offset = image_count - SEEN_W'(pat_len);
        res.found = 1'b1;
        res.addr = base_addr + ADDR_W'(offset);
        awaited_outcomes.insert(awaited_outcomes.size(), res);
        image_done = 1'b1;
      end else if (last) begin
        res = '0;
        awaited_outcomes.insert(awaited_outcomes.size(), res);
      end
    end
    if (last) begin
      for (int k = 0; k < REG_PATTERN_BYTES; k++) recent_bytes[k] = '0;
      image_count = '0;
      image_done = 1'b0;
    end
  endfunction

  function automatic int idle_span(logic enable);
    int r;
    if (!enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_image(byte_list_t img);
    image_byte_t ib;
    for (int i = 0; i < img.size(); i++) begin
      ib.data = img[i];
      ib.last = (i == img.size() - 1);
      image_bytes_q.insert(image_bytes_q.size(), ib);
    end
  endfunction

  // Mostly images that carry the pattern (wildcards filled at random), some
  // with one byte disturbed, the rest plain noise.
  function automatic int queue_random_image();
    byte_list_t img;
    int kind, len, pre, post, flip;
    logic [DATA_W-1:0] b;
    len = int'(pat_len);
    kind = $urandom_range(0, 9);
    pre = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
    post = $urandom_range(0, 5);
    flip = (kind >= 6 && kind < 8 && len > 0) ? $urandom_range(0, len - 1) : -1;
    repeat (pre) img.insert(img.size(), DATA_W'($urandom));
    if (kind < 8 && len >= 1 && len <= REG_PATTERN_BYTES) begin
      for (int j = 0; j < len; j++) begin
        b = cmp_mask[j] ? pattern_byte(j) : DATA_W'($urandom);
        if (j == flip) b = b ^ (8'h01 << $urandom_range(0, 7));
        img.insert(img.size(), b);
      end
    end else begin
      repeat ($urandom_range(0, 8)) img.insert(img.size(), DATA_W'($urandom));
    end
    repeat (post) img.insert(img.size(), DATA_W'($urandom));
    if (img.size() == 0) img.insert(img.size(), DATA_W'($urandom));
    queue_image(img);
    return img.size();
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_PAT_0_7, REG_PAT_8_15, REG_PAT_16_23, REG_PAT_24_31: begin
        pat_words[idx[1:0]] = value;
      end
      REG_MASK: begin
        cmp_mask = value[MASK_W-1:0];
      end
      REG_LENGTH: begin
        pat_len = value[LEN_W-1:0];
      end
      REG_BASE: begin
        base_addr = value;
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_scan(logic [4*CFG_W-1:0] pattern, logic [MASK_W-1:0] mask,
                          logic [LEN_W-1:0] len, logic [ADDR_W-1:0] base);
    write_reg(REG_PAT_0_7, pattern[0*CFG_W +: CFG_W]);
    write_reg(REG_PAT_8_15, pattern[1*CFG_W +: CFG_W]);
    write_reg(REG_PAT_16_23, pattern[2*CFG_W +: CFG_W]);
    write_reg(REG_PAT_24_31, pattern[3*CFG_W +: CFG_W]);
    write_reg(REG_MASK, CFG_W'(mask));
    write_reg(REG_LENGTH, CFG_W'(len));
    write_reg(REG_BASE, base);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every byte is taken and every outcome has arrived, then lets
  // the block finish any byte that causes no result. The check is made on the
  // falling edge so that it sees the settled state of the last rising edge.
  task automatic drain();
    @(negedge clk);
    while (image_bytes_q.size() != 0 || in_valid || awaited_outcomes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Byte sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) scan_byte(in_data_byte, in_last_byte);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (image_bytes_q.size() > 0) begin
          offered_byte = image_bytes_q.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= offered_byte.data;
          in_last_byte <= offered_byte.last;
          gap_left = idle_span(gaps_on);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver and checker.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_outcomes.size() == 0) begin
          $error("unexpected result: found=%0b match_address=%h", out_found, out_match_address);
          mismatch_count++;
        end else begin
          awaited = awaited_outcomes.pop_front();
          if (out_found !== awaited.found) begin
            $error("found: expected %0b, got %0b", awaited.found, out_found);
            mismatch_count++;
          end
          if (out_match_address !== awaited.addr) begin
            $error("match_address: expected %h, got %h", awaited.addr, out_match_address);
            mismatch_count++;
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        hold_left = idle_span(stalls_on);
        out_ready <= (hold_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("masked_byte_pattern_scan_core_test: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [4*CFG_W-1:0] pattern;
    logic [MASK_W-1:0]  mask;
    logic [LEN_W-1:0]   len;
    logic [ADDR_W-1:0]  base;
    int r, phase_items;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Registers at their reset values: zero length never matches.
    queue_image('{8'h00, 8'hFF, 8'h00});
    drain();

    set_scan(256'h332211, 32'h7, 6'd3, 64'h100);
    // A write to the unused index must leave every register alone.
    write_reg(REG_SPARE, '1);
    @(posedge clk);
    cfg_we <= 1'b0;
    queue_image('{8'h11, 8'h22, 8'h33});                      // match on the last byte
    queue_image('{8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55}); // bytes after the match
    queue_image('{8'h11, 8'h22});                             // image shorter than pattern
    drain();

    // Wildcard in the middle byte.
    set_scan(256'h332211, 32'h5, 6'd3, 64'h100);
    queue_image('{8'h11, 8'hA5, 8'h33});
    queue_image('{8'h11, 8'hA5, 8'h34});
    drain();

    // Length above the pattern storage never matches.
    set_scan(256'h332211, 32'h7, 6'd40, 64'h100);
    queue_image('{8'h11, 8'h22, 8'h33});
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int i = 0; i < 8; i++) pattern[i*32 +: 32] = $urandom;
      r = $urandom_range(0, 9);
      mask = (r == 0) ? '1 : (r == 1) ? '0 : MASK_W'($urandom);
      r = $urandom_range(0, 19);
      if (r == 0) len = '0;
      else if (r == 1) len = LEN_W'($urandom_range(33, 63));
      else if (r < 6) len = LEN_W'($urandom_range(17, 32));
      else len = LEN_W'($urandom_range(1, 8));
      r = $urandom_range(0, 9);
      base = (r == 0) ? '1 : (r == 1) ? '0 : {$urandom, $urandom};
      case (p)
        0: begin
          pattern = '1;
          mask = '1;
          len = 6'd32;
          base = '1;
        end
        1: begin
          pattern = '0;
          mask = '0;
          len = 6'd1;
          base = '0;
        end
        2: len = 6'd63;
        3: len = 6'd0;
        default: begin
        end
      endcase
      gaps_on = (p % 4 != 1);
      stalls_on = (p % 4 != 1);
      set_scan(pattern, mask, len, base);
      if (p == 5) begin
        // Receiver holds off while the sender keeps offering bytes.
        gaps_on = 1'b0;
        hold_request = 1'b1;
      end
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) phase_items += queue_random_image();
      drain();
    end

    if (mismatch_count == 0) begin
      $display("masked_byte_pattern_scan_core_test: done, clean");
    end else begin
      $display("masked_byte_pattern_scan_core_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_cell.sv
hw/rtl/mbps_chain.sv
hw/rtl/masked_byte_pattern_scan_core.sv
test/masked_byte_pattern_scan_core_test.sv
